@@ design/fragment_depth_alpha_blend_ops_macros.svh @@
// Assertion helpers for the raster operation block
`ifndef FRAGMENT_DEPTH_ALPHA_BLEND_OPS_MACROS_SVH
`define FRAGMENT_DEPTH_ALPHA_BLEND_OPS_MACROS_SVH

`ifndef NO_ASSERTIONS

`define FDAB_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fdab check failed");

`define FDAB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fdab check failed");

`else

`define FDAB_ASSERT_SAME(lbl, clk, rst_n, ante, cons)

`define FDAB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ design/fdab_pkg.sv @@
package fdab_pkg;

    localparam int DEPTH_BITS_DEFAULT = 24;
    localparam int CFG_INDEX_W        = 4;
    localparam int CFG_DATA_W         = 32;
    localparam int CHAN_W             = 8;
    localparam int NUM_CHAN           = 4;
    localparam int ALPHA_CHAN         = 3;
    localparam int PROD_W             = 2 * CHAN_W;
    localparam int SUM_W              = PROD_W + 1;
    localparam int ROUND_W            = SUM_W + 1;
    localparam int QUOT_W             = ROUND_W - CHAN_W;
    localparam int REM_W              = QUOT_W + 1;

    localparam logic [CHAN_W-1:0]  CHAN_MAX   = 8'hFF;
    localparam logic [CHAN_W-1:0]  CHAN_ZERO  = 8'h00;
    localparam logic [ROUND_W-1:0] ROUND_BIAS = ROUND_W'(127);
    localparam logic [REM_W-1:0]   DIV_ONE    = REM_W'(255);
    localparam logic [REM_W-1:0]   DIV_TWO    = REM_W'(510);

    // compare function codes
    localparam logic [3:0] CMP_NEVER    = 4'd0;
    localparam logic [3:0] CMP_LESS     = 4'd1;
    localparam logic [3:0] CMP_EQUAL    = 4'd2;
    localparam logic [3:0] CMP_LEQUAL   = 4'd3;
    localparam logic [3:0] CMP_GREATER  = 4'd4;
    localparam logic [3:0] CMP_NOTEQUAL = 4'd5;
    localparam logic [3:0] CMP_GEQUAL   = 4'd6;
    localparam logic [3:0] CMP_ALWAYS   = 4'd7;
    localparam logic [3:0] CMP_OFF      = 4'd8;

    // blend factor codes
    localparam logic [3:0] BF_ZERO          = 4'd0;
    localparam logic [3:0] BF_ONE           = 4'd1;
    localparam logic [3:0] BF_SRC_COLOR     = 4'd2;
    localparam logic [3:0] BF_INV_SRC_COLOR = 4'd3;
    localparam logic [3:0] BF_DST_COLOR     = 4'd4;
    localparam logic [3:0] BF_INV_DST_COLOR = 4'd5;
    localparam logic [3:0] BF_SRC_ALPHA     = 4'd6;
    localparam logic [3:0] BF_INV_SRC_ALPHA = 4'd7;
    localparam logic [3:0] BF_DST_ALPHA     = 4'd8;
    localparam logic [3:0] BF_INV_DST_ALPHA = 4'd9;
    localparam logic [3:0] BF_ALPHA_SAT     = 4'd10;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DEPTH_FUNC   = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEPTH_WRITE  = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA_FUNC   = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA_REF    = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLEND_ENABLE = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLEND_SRC    = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLEND_DST    = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_WRITE_MASK   = 4'd7;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] quad_t;
    typedef logic [NUM_CHAN-1:0][SUM_W-1:0] sum_quad_t;

    typedef struct packed {
        logic pass;
        logic dwrite;
    } frag_ctl_t;

    typedef struct packed {
        logic [3:0]  depth_func;
        logic        depth_write_enable;
        logic [3:0]  alpha_func;
        chan_t       alpha_ref;
        logic        blend_enable;
        logic [3:0]  blend_src_factor;
        logic [3:0]  blend_dst_factor;
        logic [31:0] color_write_mask;
    } rop_cfg_t;

    function automatic logic cmp_pass(input logic [3:0] func, input logic lt,
                                      input logic eq);
        logic res;
        case (func)
            CMP_NEVER:    res = 1'b0;
            CMP_LESS:     res = lt;
            CMP_EQUAL:    res = eq;
            CMP_LEQUAL:   res = lt | eq;
            CMP_GREATER:  res = ~lt & ~eq;
            CMP_NOTEQUAL: res = ~eq;
            CMP_GEQUAL:   res = ~lt;
            default:      res = 1'b1;
        endcase
        return res;
    endfunction

    function automatic chan_t blend_factor(input logic [3:0] sel, input logic allow_sat,
                                           input logic is_alpha, input chan_t sa,
                                           input chan_t sc, input chan_t da,
                                           input chan_t dc);
        chan_t f;
        chan_t inv_da;
        inv_da = CHAN_MAX - da;
        case (sel)
            BF_ZERO:          f = CHAN_ZERO;
            BF_ONE:           f = CHAN_MAX;
            BF_SRC_COLOR:     f = sc;
            BF_INV_SRC_COLOR: f = CHAN_MAX - sc;
            BF_DST_COLOR:     f = dc;
            BF_INV_DST_COLOR: f = CHAN_MAX - dc;
            BF_SRC_ALPHA:     f = sa;
            BF_INV_SRC_ALPHA: f = CHAN_MAX - sa;
            BF_DST_ALPHA:     f = da;
            BF_INV_DST_ALPHA: f = inv_da;
            BF_ALPHA_SAT:
            begin
                if (!allow_sat)
                begin
                    f = CHAN_ZERO;
                end
                else if (is_alpha)
                begin
                    f = CHAN_MAX;
                end
                else
                begin
                    f = (sa < inv_da) ? sa : inv_da;
                end
            end
            default:          f = CHAN_ZERO;
        endcase
        return f;
    endfunction

endpackage

@@ design/fdab_test.sv @@
module fdab_test
    import fdab_pkg::*;
#(
    parameter int DEPTH_BITS = DEPTH_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic                  up_valid,
    input  rop_cfg_t              cfg,
    input  logic                  covered,
    input  logic [DEPTH_BITS-1:0] frag_depth,
    input  quad_t                 src,
    input  logic [31:0]           dst_pixel,
    input  logic [DEPTH_BITS-1:0] dst_depth,
    output logic                  valid,
    output frag_ctl_t             ctl,
    output quad_t                 src_q,
    output quad_t                 dst_q,
    output quad_t                 sf_q,
    output quad_t                 df_q,
    output logic [DEPTH_BITS-1:0] depth_q
);

    logic      valid_reg;
    frag_ctl_t ctl_reg, ctl_next;
    quad_t     src_reg, dst_reg, sf_reg, df_reg, sf_next, df_next;
    logic [DEPTH_BITS-1:0] depth_reg, depth_next;
    quad_t     dst;
    logic      depth_on, depth_ok, alpha_ok;

    assign dst = dst_pixel;

    always_comb
    begin
        depth_on = cfg.depth_func < CMP_OFF;
        depth_ok = cmp_pass(cfg.depth_func, frag_depth < dst_depth, frag_depth == dst_depth);
        alpha_ok = cmp_pass(cfg.alpha_func, src[ALPHA_CHAN] < cfg.alpha_ref,
                            src[ALPHA_CHAN] == cfg.alpha_ref);
        ctl_next.pass   = covered & depth_ok & alpha_ok;
        ctl_next.dwrite = ctl_next.pass & depth_on & cfg.depth_write_enable;
        depth_next      = ctl_next.dwrite ? frag_depth : dst_depth;
        for (int i = 0; i < NUM_CHAN; i++)
        begin
            // blending off: src*255 + dst*0 rounds back to src
            if (cfg.blend_enable)
            begin
                sf_next[i] = blend_factor(cfg.blend_src_factor, 1'b1, i == ALPHA_CHAN,
                                          src[ALPHA_CHAN], src[i], dst[ALPHA_CHAN], dst[i]);
                df_next[i] = blend_factor(cfg.blend_dst_factor, 1'b0, i == ALPHA_CHAN,
                                          src[ALPHA_CHAN], src[i], dst[ALPHA_CHAN], dst[i]);
            end
            else
            begin
                sf_next[i] = CHAN_MAX;
                df_next[i] = CHAN_ZERO;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && up_valid)
        begin
            ctl_reg   <= ctl_next;
            src_reg   <= src;
            dst_reg   <= dst;
            sf_reg    <= sf_next;
            df_reg    <= df_next;
            depth_reg <= depth_next;
        end
    end

    assign valid   = valid_reg;
    assign ctl     = ctl_reg;
    assign src_q   = src_reg;
    assign dst_q   = dst_reg;
    assign sf_q    = sf_reg;
    assign df_q    = df_reg;
    assign depth_q = depth_reg;

endmodule

@@ design/fdab_mul.sv @@
module fdab_mul
    import fdab_pkg::*;
#(
    parameter int DEPTH_BITS = DEPTH_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic                  up_valid,
    input  frag_ctl_t             up_ctl,
    input  quad_t                 src,
    input  quad_t                 dst,
    input  quad_t                 sf,
    input  quad_t                 df,
    input  logic [DEPTH_BITS-1:0] up_depth,
    output logic                  valid,
    output frag_ctl_t             ctl,
    output sum_quad_t             sum_q,
    output quad_t                 dst_q,
    output logic [DEPTH_BITS-1:0] depth_q
);

    logic      valid_reg;
    frag_ctl_t ctl_reg;
    sum_quad_t sum_reg, sum_next;
    quad_t     dst_reg;
    logic [DEPTH_BITS-1:0] depth_reg;
    logic [NUM_CHAN-1:0][PROD_W-1:0] sp, dp;

    always_comb
    begin
        for (int i = 0; i < NUM_CHAN; i++)
        begin
            sp[i]       = PROD_W'(src[i]) * PROD_W'(sf[i]);
            dp[i]       = PROD_W'(dst[i]) * PROD_W'(df[i]);
            sum_next[i] = SUM_W'(sp[i]) + SUM_W'(dp[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && up_valid)
        begin
            ctl_reg   <= up_ctl;
            sum_reg   <= sum_next;
            dst_reg   <= dst;
            depth_reg <= up_depth;
        end
    end

    assign valid   = valid_reg;
    assign ctl     = ctl_reg;
    assign sum_q   = sum_reg;
    assign dst_q   = dst_reg;
    assign depth_q = depth_reg;

endmodule

@@ design/fdab_norm.sv @@
module fdab_norm
    import fdab_pkg::*;
#(
    parameter int DEPTH_BITS = DEPTH_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic                  up_valid,
    input  frag_ctl_t             up_ctl,
    input  sum_quad_t             sum,
    input  quad_t                 dst,
    input  logic [DEPTH_BITS-1:0] up_depth,
    input  logic [31:0]           write_mask,
    output logic                  valid,
    output logic [31:0]           pixel,
    output logic                  pixel_wr,
    output logic [DEPTH_BITS-1:0] depth,
    output logic                  depth_wr
);

    logic        valid_reg;
    logic [31:0] pixel_reg, pixel_next;
    logic        pixel_wr_reg, depth_wr_reg;
    logic [DEPTH_BITS-1:0] depth_reg;
    quad_t       npix;
    logic [NUM_CHAN-1:0][ROUND_W-1:0] t;
    logic [NUM_CHAN-1:0][QUOT_W-1:0]  q0, q;
    logic [NUM_CHAN-1:0][REM_W-1:0]   r;

    // (sum + 127) / 255: estimate by >> 8, then fix up by at most two
    always_comb
    begin
        for (int i = 0; i < NUM_CHAN; i++)
        begin
            t[i]  = ROUND_W'(sum[i]) + ROUND_BIAS;
            q0[i] = t[i][ROUND_W-1:CHAN_W];
            r[i]  = REM_W'(t[i][CHAN_W-1:0]) + REM_W'(q0[i]);
            if (r[i] >= DIV_TWO)
            begin
                q[i] = q0[i] + QUOT_W'(2);
            end
            else if (r[i] >= DIV_ONE)
            begin
                q[i] = q0[i] + QUOT_W'(1);
            end
            else
            begin
                q[i] = q0[i];
            end
            npix[i] = (q[i] > QUOT_W'(CHAN_MAX)) ? CHAN_MAX : q[i][CHAN_W-1:0];
        end
        if (up_ctl.pass)
        begin
            pixel_next = (npix & write_mask) | (dst & ~write_mask);
        end
        else
        begin
            pixel_next = dst;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && up_valid)
        begin
            pixel_reg    <= pixel_next;
            pixel_wr_reg <= up_ctl.pass;
            depth_reg    <= up_depth;
            depth_wr_reg <= up_ctl.dwrite;
        end
    end

    assign valid    = valid_reg;
    assign pixel    = pixel_reg;
    assign pixel_wr = pixel_wr_reg;
    assign depth    = depth_reg;
    assign depth_wr = depth_wr_reg;

endmodule

@@ design/fragment_depth_alpha_blend_ops.sv @@
// Stages, in order from input accept to result valid: test, multiply, round.
// Throughput: one fragment per cycle while out_stall is low; each stage advances
// when the one after it is empty or moving, so bubbles close up under output stall.
// Reset: rst_n async active low clears all stage valid bits and loads register
// defaults (tests off, depth write on, blend off, src one, dst zero, full mask).
`include "fragment_depth_alpha_blend_ops_macros.svh"

module fragment_depth_alpha_blend_ops
    import fdab_pkg::*;
#(
    parameter int DEPTH_BITS = DEPTH_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   covered,
    input  logic [DEPTH_BITS-1:0]  frag_depth,
    input  logic [7:0]             src_alpha,
    input  logic [7:0]             src_red,
    input  logic [7:0]             src_green,
    input  logic [7:0]             src_blue,
    input  logic [31:0]            dst_pixel,
    input  logic [DEPTH_BITS-1:0]  dst_depth,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [31:0]            pixel_out,
    output logic                   pixel_write,
    output logic [DEPTH_BITS-1:0]  depth_out,
    output logic                   depth_write
);

    rop_cfg_t cfg_reg;

    logic      rdy_b, rdy_c, rdy_d;
    logic      vb, vc;
    frag_ctl_t ctl_b, ctl_c;
    quad_t     src_b, dst_b, sf_b, df_b, dst_c;
    sum_quad_t sum_c;
    logic [DEPTH_BITS-1:0] depth_b, depth_c;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.depth_func         <= CMP_OFF;
            cfg_reg.depth_write_enable <= 1'b1;
            cfg_reg.alpha_func         <= CMP_OFF;
            cfg_reg.alpha_ref          <= CHAN_ZERO;
            cfg_reg.blend_enable       <= 1'b0;
            cfg_reg.blend_src_factor   <= BF_ONE;
            cfg_reg.blend_dst_factor   <= BF_ZERO;
            cfg_reg.color_write_mask   <= '1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DEPTH_FUNC:   cfg_reg.depth_func         <= cfg_data[3:0];
                CFG_DEPTH_WRITE:  cfg_reg.depth_write_enable <= cfg_data[0];
                CFG_ALPHA_FUNC:   cfg_reg.alpha_func         <= cfg_data[3:0];
                CFG_ALPHA_REF:    cfg_reg.alpha_ref          <= cfg_data[7:0];
                CFG_BLEND_ENABLE: cfg_reg.blend_enable       <= cfg_data[0];
                CFG_BLEND_SRC:    cfg_reg.blend_src_factor   <= cfg_data[3:0];
                CFG_BLEND_DST:    cfg_reg.blend_dst_factor   <= cfg_data[3:0];
                CFG_WRITE_MASK:   cfg_reg.color_write_mask   <= cfg_data[31:0];
                default:          ;
            endcase
        end
    end

    assign rdy_d    = !out_valid || !out_stall;
    assign rdy_c    = !vc || rdy_d;
    assign rdy_b    = !vb || rdy_c;
    assign in_stall = !rdy_b;

    fdab_test #(.DEPTH_BITS(DEPTH_BITS)) u_test (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (rdy_b),
        .up_valid   (in_valid),
        .cfg        (cfg_reg),
        .covered    (covered),
        .frag_depth (frag_depth),
        .src        ({src_alpha, src_red, src_green, src_blue}),
        .dst_pixel  (dst_pixel),
        .dst_depth  (dst_depth),
        .valid      (vb),
        .ctl        (ctl_b),
        .src_q      (src_b),
        .dst_q      (dst_b),
        .sf_q       (sf_b),
        .df_q       (df_b),
        .depth_q    (depth_b)
    );

    fdab_mul #(.DEPTH_BITS(DEPTH_BITS)) u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (rdy_c),
        .up_valid (vb),
        .up_ctl   (ctl_b),
        .src      (src_b),
        .dst      (dst_b),
        .sf       (sf_b),
        .df       (df_b),
        .up_depth (depth_b),
        .valid    (vc),
        .ctl      (ctl_c),
        .sum_q    (sum_c),
        .dst_q    (dst_c),
        .depth_q  (depth_c)
    );

    fdab_norm #(.DEPTH_BITS(DEPTH_BITS)) u_norm (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (rdy_d),
        .up_valid   (vc),
        .up_ctl     (ctl_c),
        .sum        (sum_c),
        .dst        (dst_c),
        .up_depth   (depth_c),
        .write_mask (cfg_reg.color_write_mask),
        .valid      (out_valid),
        .pixel      (pixel_out),
        .pixel_wr   (pixel_write),
        .depth      (depth_out),
        .depth_wr   (depth_write)
    );

    `FDAB_ASSERT_SAME(a_full_no_accept, clk, rst_n, out_valid && out_stall && vb && vc, in_stall)
    `FDAB_ASSERT_SAME(a_dwrite_needs_pass, clk, rst_n, out_valid && depth_write, pixel_write)
    `FDAB_ASSERT_NEXT(a_drain, clk, rst_n, out_valid && !out_stall && !vc, !out_valid)

endmodule
